// ----- rtl/core/integer_to_ascii_formatter_macros.svh -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_macros.svh
// Assertion shorthands for the integer formatter, clocked on clock and
// held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication.
`define ITOA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and character constants of the integer formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned NUM_DIGITS = 22;   // octal needs the most digits
   localparam int unsigned NDIG_W     = 5;
   localparam int unsigned BITCNT_W   = 6;
   localparam int unsigned MINW_W     = 6;
   localparam int unsigned CHAR_W     = 8;

   // base selector codes; the unused code formats as hex
   localparam logic [1:0] BASE_OCT = 2'd0;
   localparam logic [1:0] BASE_DEC = 2'd1;
   localparam logic [1:0] BASE_HEX = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic              done;
      logic [NDIG_W-1:0] ndig;
   } itoa_conv_status_type;

   typedef struct packed {
      logic negative;
      logic zero_pad;
      logic upper_case;
   } itoa_setup_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
      logic [CHAR_W-1:0] dx;
      dx = CHAR_W'(d);
      if (d < DIGIT_W'(10)) begin
         return CHAR_ZERO + dx;
      end
      return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + dx - CHAR_W'(10);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/itoa_conv.sv -----
// ----------------------------------------------------------------------------
// itoa_conv
// Bit-serial radix converter: shifts the magnitude in MSB first, one bit a
// cycle, into a row of 4-bit digit cells and tracks the digit count.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_conv (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [itoa_pkg::VALUE_W-1:0]       load_mag,
   input  logic [1:0]                         load_base,
   input  logic [itoa_pkg::NDIG_W-1:0]        rd_index,
   output logic [itoa_pkg::DIGIT_W-1:0]       rd_digit,
   output itoa_pkg::itoa_conv_status_type     status
);

   logic [itoa_pkg::VALUE_W-1:0]  mag_ff, mag_in;
   logic [1:0]                    base_ff;
   logic [itoa_pkg::DIGIT_W-1:0]  digits_ff [itoa_pkg::NUM_DIGITS];
   logic [itoa_pkg::DIGIT_W-1:0]  digits_in [itoa_pkg::NUM_DIGITS];
   logic [itoa_pkg::NDIG_W-1:0]   ndig_ff, ndig_in;
   logic [itoa_pkg::BITCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [itoa_pkg::NUM_DIGITS:0] carry;

   // one doubling step per cell; the carry between cells is a plain wire
   always_comb begin
      logic [itoa_pkg::DIGIT_W-1:0] d;
      logic [itoa_pkg::DIGIT_W-1:0] adj;
      carry[0] = mag_ff[itoa_pkg::VALUE_W-1];
      for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
         d   = digits_ff[i];
         adj = (d >= itoa_pkg::DIGIT_W'(5)) ? d + itoa_pkg::DIGIT_W'(3) : d;
         unique case (base_ff)
            itoa_pkg::BASE_OCT: begin
               digits_in[i] = {1'b0, d[1:0], carry[i]};
               carry[i+1]   = d[2];
            end
            itoa_pkg::BASE_DEC: begin
               digits_in[i] = {adj[2:0], carry[i]};
               carry[i+1]   = adj[3];
            end
            default: begin
               digits_in[i] = {d[2:0], carry[i]};
               carry[i+1]   = d[3];
            end
         endcase
      end
      mag_in  = {mag_ff[itoa_pkg::VALUE_W-2:0], 1'b0};
      // the count grows by one exactly when a carry enters the first empty cell
      ndig_in = ndig_ff + itoa_pkg::NDIG_W'(carry[ndig_ff]);
   end

   always_comb begin
      run_in     = run_ff;
      bit_cnt_in = bit_cnt_ff;
      done_in    = 1'b0;
      if (load) begin
         run_in     = 1'b1;
         bit_cnt_in = '0;
      end else if (run_ff) begin
         bit_cnt_in = bit_cnt_ff + itoa_pkg::BITCNT_W'(1);
         if (bit_cnt_ff == '1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         bit_cnt_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         run_ff     <= run_in;
         bit_cnt_ff <= bit_cnt_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff  <= load_mag;
         base_ff <= load_base;
         ndig_ff <= '0;
         for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
            digits_ff[i] <= '0;
         end
      end else if (run_ff) begin
         mag_ff  <= mag_in;
         ndig_ff <= ndig_in;
         for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
            digits_ff[i] <= digits_in[i];
         end
      end
   end

   assign rd_digit = (rd_index < itoa_pkg::NDIG_W'(itoa_pkg::NUM_DIGITS)) ?
                     digits_ff[rd_index] : '0;

   assign status.done = done_ff;
   assign status.ndig = ndig_ff;

endmodule

`default_nettype wire

// ----- rtl/core/itoa_emit.sv -----
// ----------------------------------------------------------------------------
// itoa_emit
// Field sequencer: counts the characters of one field down, picks padding,
// sign or digit for each, and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_emit #(
   parameter int unsigned CNT_W = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  itoa_pkg::itoa_setup_type          setup,
   input  logic [CNT_W-1:0]                  width,
   input  logic [itoa_pkg::NDIG_W-1:0]       ndig,
   output logic [itoa_pkg::NDIG_W-1:0]       rd_index,
   input  logic [itoa_pkg::DIGIT_W-1:0]      rd_digit,
   output logic                              fin,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] character
   output logic                              rsp_tlast
);

   itoa_pkg::itoa_setup_type      setup_ff;
   logic                          active_ff, active_in;
   logic [CNT_W-1:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]              total_ff;
   logic [CNT_W-1:0]              ndig_ff;
   logic                          tvalid_ff, tvalid_in;
   logic [itoa_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                          last_ff;
   logic [CNT_W-1:0]              ndig_eff;
   logic [CNT_W-1:0]              body;
   logic [CNT_W-1:0]              total;
   logic                          load;
   logic                          in_digits;
   logic                          is_minus;

   assign ndig_eff = (ndig == '0) ? CNT_W'(1) : CNT_W'(ndig);
   assign body     = ndig_eff + CNT_W'(setup.negative);
   assign total    = (width > body) ? width : body;

   assign load      = active_ff && (!tvalid_ff || rsp_tready);
   assign fin       = load && (rem_ff == CNT_W'(1));
   assign in_digits = (rem_ff <= ndig_ff);
   assign rd_index  = in_digits ? itoa_pkg::NDIG_W'(rem_ff - CNT_W'(1)) : '0;

   // zero padding puts the sign first, space padding just before the digits
   assign is_minus = setup_ff.negative &&
                     ((setup_ff.zero_pad && (rem_ff == total_ff)) ||
                      (!setup_ff.zero_pad && (rem_ff == ndig_ff + CNT_W'(1))));

   always_comb begin
      priority if (in_digits) begin
         char_in = itoa_pkg::digit_char(rd_digit, setup_ff.upper_case);
      end else if (is_minus) begin
         char_in = itoa_pkg::CHAR_MINUS;
      end else if (setup_ff.zero_pad) begin
         char_in = itoa_pkg::CHAR_ZERO;
      end else begin
         char_in = itoa_pkg::CHAR_SPACE;
      end
   end

   always_comb begin
      active_in = active_ff;
      rem_in    = rem_ff;
      tvalid_in = tvalid_ff;
      if (rsp_tready) begin
         tvalid_in = 1'b0;
      end
      if (load) begin
         tvalid_in = 1'b1;
         rem_in    = rem_ff - CNT_W'(1);
      end
      if (fin) begin
         active_in = 1'b0;
      end
      if (start) begin
         active_in = 1'b1;
         rem_in    = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         tvalid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         tvalid_ff <= tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (start) begin
         setup_ff <= setup;
         total_ff <= total;
         ndig_ff  <= ndig_eff;
      end
      if (load) begin
         char_ff <= char_in;
         last_ff <= (rem_ff == CNT_W'(1));
      end
   end

   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// First character: the request is taken, the bit-serial converter shifts in
//   all 64 bits, the digits are handed over, and the output register is loaded.
// Requests: a new one is taken once the previous field (1..63 characters) has
//   its last character loaded; output: one character per cycle unless stalled.
// Reset: synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
   parameter int unsigned MAX_FIELD_WIDTH = 63
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [63:0] value, [65:64] base_select, [66] upper_case, [72:67] pad_width,
   // [73] zero_pad, [79:74] zero
   input  logic [79:0] req_tdata,
   // [0] signed_mode
   input  logic        req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] character
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   // counters must hold the widest field and the longest digit string plus sign
   localparam int unsigned CNT_W = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int unsigned WCLAMP_W = itoa_pkg::MINW_W + 1;
   localparam logic [itoa_pkg::NDIG_W-1:0] NDIG_MAX = itoa_pkg::NDIG_W'(itoa_pkg::NUM_DIGITS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } itoa_state_type;

   itoa_state_type                    state_ff, state_in;
   itoa_pkg::itoa_setup_type          setup_ff, setup_in;
   logic [CNT_W-1:0]                  width_ff, width_in;
   itoa_pkg::itoa_conv_status_type    conv_st;
   logic [itoa_pkg::NDIG_W-1:0]       rd_index;
   logic [itoa_pkg::DIGIT_W-1:0]      rd_digit;
   logic                              req_accept;
   logic                              emit_start;
   logic                              emit_fin;

   // unpacked request fields
   logic [itoa_pkg::VALUE_W-1:0]      req_value;
   logic [1:0]                        req_base;
   logic                              req_upper;
   logic [itoa_pkg::MINW_W-1:0]       req_pad_width;
   logic                              req_zero_pad;
   logic                              req_negative;
   logic [itoa_pkg::VALUE_W-1:0]      req_mag;
   logic [WCLAMP_W-1:0]               req_width_raw;

   assign req_value     = req_tdata[63:0];
   assign req_base      = req_tdata[65:64];
   assign req_upper     = req_tdata[66];
   assign req_pad_width = req_tdata[72:67];
   assign req_zero_pad  = req_tdata[73];

   // take in a request only between fields; the output register may still
   // hold the last character of the previous one
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // a negative signed value prints its two's complement magnitude, which
   // also covers the most negative value
   assign req_negative = req_tuser && req_value[itoa_pkg::VALUE_W-1];
   assign req_mag      = req_negative ? (~req_value + itoa_pkg::VALUE_W'(1)) : req_value;

   // a zero width counts as one; clamp to the largest supported field
   always_comb begin
      req_width_raw = (req_pad_width == '0) ? WCLAMP_W'(1) : WCLAMP_W'(req_pad_width);
      if (req_width_raw > WCLAMP_W'(MAX_FIELD_WIDTH)) begin
         req_width_raw = WCLAMP_W'(MAX_FIELD_WIDTH);
      end
   end

   always_comb begin
      setup_in = setup_ff;
      width_in = width_ff;
      if (req_accept) begin
         setup_in.negative   = req_negative;
         setup_in.zero_pad   = req_zero_pad;
         setup_in.upper_case = req_upper;
         width_in            = CNT_W'(req_width_raw);
      end
   end

   // hand the digits over as soon as the converter has shifted in all bits
   assign emit_start = (state_ff == ST_CONV) && conv_st.done;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_st.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fin) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request settings are payload and need no reset
   always_ff @(posedge clock) begin
      setup_ff <= setup_in;
      width_ff <= width_in;
   end

   itoa_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_mag  (req_mag),
      .load_base (req_base),
      .rd_index  (rd_index),
      .rd_digit  (rd_digit),
      .status    (conv_st)
   );

   itoa_emit #(
      .CNT_W (CNT_W)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (emit_start),
      .setup      (setup_ff),
      .width      (width_ff),
      .ndig       (conv_st.ndig),
      .rd_index   (rd_index),
      .rd_digit   (rd_digit),
      .fin        (emit_fin),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // the converter finishes only while the sequencer waits for it
   `ITOA_ASSERT_IMP(a_conv_done_in_conv, conv_st.done, state_ff == ST_CONV, "done outside CONV")
   // a 64-bit magnitude never spills past the digit row
   `ITOA_ASSERT_IMP(a_ndig_in_range, conv_st.done, conv_st.ndig <= NDIG_MAX, "digit count too big")
   // the final character of a field is presented with tlast
   `ITOA_ASSERT_NEXT(a_fin_sets_last, emit_fin, rsp_tvalid && rsp_tlast, "end without tlast")
   // a field only ends while the sequencer is emitting
   `ITOA_ASSERT_IMP(a_fin_in_emit, emit_fin, state_ff == ST_EMIT, "end outside EMIT")

endmodule

`default_nettype wire
